>>> hw/rtl/xit_pkg.sv
// shared types, codes and constants of the xml item tokenizer
`timescale 1ns / 1ps

package xit_pkg;

  // request commands
  localparam logic [1:0] CMD_BYTE   = 2'd0;
  localparam logic [1:0] CMD_END    = 2'd1;
  localparam logic [1:0] CMD_BEGIN  = 2'd2;
  localparam logic [1:0] CMD_IGNORE = 2'd3;

  // item kinds
  localparam logic [3:0] KIND_START = 4'd0;
  localparam logic [3:0] KIND_END   = 4'd1;
  localparam logic [3:0] KIND_SELF  = 4'd2;
  localparam logic [3:0] KIND_CMT   = 4'd3;
  localparam logic [3:0] KIND_CDATA = 4'd4;
  localparam logic [3:0] KIND_PI    = 4'd5;
  localparam logic [3:0] KIND_DTD   = 4'd6;
  localparam logic [3:0] KIND_TEXT  = 4'd7;
  localparam logic [3:0] KIND_STOP  = 4'd8;

  // error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_UNMATCHED = 2'd1;
  localparam logic [1:0] ERR_DEPTH     = 2'd2;

  // scanner phases
  localparam logic [4:0] PH_IDLE          = 5'd0;
  localparam logic [4:0] PH_TEXT          = 5'd1;
  localparam logic [4:0] PH_LT            = 5'd2;
  localparam logic [4:0] PH_ENDTAG        = 5'd3;
  localparam logic [4:0] PH_STARTTAG      = 5'd4;
  localparam logic [4:0] PH_PI            = 5'd5;
  localparam logic [4:0] PH_PI_Q          = 5'd6;
  localparam logic [4:0] PH_BANG          = 5'd7;
  localparam logic [4:0] PH_BANG_DASH     = 5'd8;
  localparam logic [4:0] PH_CDATA_PFX     = 5'd9;
  localparam logic [4:0] PH_CMT           = 5'd10;
  localparam logic [4:0] PH_CMT_D1        = 5'd11;
  localparam logic [4:0] PH_CMT_D2        = 5'd12;
  localparam logic [4:0] PH_CD            = 5'd13;
  localparam logic [4:0] PH_CD_B1         = 5'd14;
  localparam logic [4:0] PH_CD_B2         = 5'd15;
  localparam logic [4:0] PH_DTD           = 5'd16;
  localparam logic [4:0] PH_DTD_LT        = 5'd17;
  localparam logic [4:0] PH_DTD_BANG      = 5'd18;
  localparam logic [4:0] PH_DTD_BANG_DASH = 5'd19;
  localparam logic [4:0] PH_STOPPED       = 5'd20;

  // characters
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // limits: smaller of the configured maximum and the counter range
  localparam logic [7:0] DEPTH_LIMIT = 8'd255;
  localparam logic [7:0] NEST_LIMIT  = 8'd255;
  localparam logic [2:0] CDATA_LEN   = 3'd7;
  localparam logic [15:0] LEN_MAX    = 16'hFFFF;

  typedef struct packed {
    logic [4:0]  phase;
    logic [7:0]  depth;
    logic        pop;
    logic [7:0]  nest;
    logic [2:0]  match;
    logic        recent;   // last tag byte was a slash
    logic [15:0] len;
    logic        halted;
  } xit_state_t;

  typedef struct packed {
    logic        emit;
    logic [3:0]  kind;
    logic [7:0]  depth;
    logic [15:0] len;
    logic [1:0]  err;
  } xit_result_t;

  localparam xit_state_t STATE_RESET = '{
    phase: PH_STOPPED, depth: 8'd0, pop: 1'b0, nest: 8'd0,
    match: 3'd0, recent: 1'b0, len: 16'd0, halted: 1'b1
  };

  // "[CDATA[" prefix after the bang
  function automatic logic [7:0] cdata_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h5B;
      3'd1:    c = 8'h43;
      3'd2:    c = 8'h44;
      3'd3:    c = 8'h41;
      3'd4:    c = 8'h54;
      3'd5:    c = 8'h41;
      3'd6:    c = 8'h5B;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

>>> hw/rtl/xit_step.sv
// next-state and result logic for one tokenizer request
`timescale 1ns / 1ps

module xit_step (
  input  xit_pkg::xit_state_t  cur,
  input  logic [1:0]           cmd,
  input  logic [7:0]           b,
  output xit_pkg::xit_state_t  nxt,
  output xit_pkg::xit_result_t res
);
  import xit_pkg::*;

  logic text_put;
  logic no_dash;
  logic do_nest;
  logic do_dtd;

  always_comb begin
    nxt      = cur;
    res      = '0;
    text_put = 1'b0;
    no_dash  = 1'b0;
    do_nest  = 1'b0;
    do_dtd   = 1'b0;

    if (cmd == CMD_BEGIN) begin
      nxt        = STATE_RESET;
      nxt.halted = 1'b0;
      nxt.phase  = PH_IDLE;
    end else if (cmd != CMD_IGNORE && !cur.halted) begin
      // deferred close of the previous element
      if (cur.pop) begin
        if (cur.depth != 8'd0) nxt.depth = cur.depth - 8'd1;
        nxt.pop = 1'b0;
      end

      if (cmd == CMD_END) begin
        res.err = ERR_NONE;
        if (cur.phase == PH_IDLE) begin
          nxt.len = 16'd0;
          res.err = (nxt.depth != 8'd0) ? ERR_UNMATCHED : ERR_NONE;
        end
        nxt.halted = 1'b1;
        nxt.phase  = PH_STOPPED;
        res.emit   = 1'b1;
        res.kind   = KIND_STOP;
      end else if (cur.phase == PH_IDLE) begin
        if (b > CH_SPACE) begin
          nxt.len    = 16'd1;
          nxt.nest   = 8'd0;
          nxt.match  = 3'd0;
          nxt.recent = 1'b0;
          nxt.phase  = (b == CH_LT) ? PH_LT : PH_TEXT;
        end
      end else if (cur.phase == PH_TEXT && b == CH_LT) begin
        if (nxt.depth != 8'd0) begin
          res.emit = 1'b1;
          res.kind = KIND_TEXT;
          text_put = 1'b1;
        end
        nxt.len    = 16'd1;
        nxt.nest   = 8'd0;
        nxt.match  = 3'd0;
        nxt.recent = 1'b0;
        nxt.phase  = PH_LT;
      end else begin
        if (cur.len != LEN_MAX) nxt.len = cur.len + 16'd1;
        unique case (cur.phase)
          PH_TEXT: begin
          end
          PH_LT: begin
            if (b == CH_SLASH) nxt.phase = PH_ENDTAG;
            else if (b == CH_QUEST) nxt.phase = PH_PI;
            else if (b == CH_BANG) nxt.phase = PH_BANG;
            else if (b == CH_GT) begin
              nxt.halted = 1'b1;
              nxt.phase  = PH_STOPPED;
              res.emit   = 1'b1;
              res.kind   = KIND_STOP;
              res.err    = ERR_NONE;
            end else begin
              nxt.phase  = PH_STARTTAG;
              nxt.recent = 1'b0;
            end
          end
          PH_ENDTAG: begin
            if (b == CH_GT) begin
              if (nxt.depth == 8'd0) begin
                nxt.halted = 1'b1;
                nxt.phase  = PH_STOPPED;
                res.emit   = 1'b1;
                res.kind   = KIND_STOP;
                res.err    = ERR_UNMATCHED;
              end else begin
                nxt.pop   = 1'b1;
                nxt.phase = PH_IDLE;
                res.emit  = 1'b1;
                res.kind  = KIND_END;
              end
            end
          end
          PH_STARTTAG: begin
            if (b != CH_GT) begin
              nxt.recent = (b == CH_SLASH);
            end else if (nxt.depth >= DEPTH_LIMIT) begin
              nxt.halted = 1'b1;
              nxt.phase  = PH_STOPPED;
              res.emit   = 1'b1;
              res.kind   = KIND_STOP;
              res.err    = ERR_DEPTH;
            end else begin
              nxt.depth = nxt.depth + 8'd1;
              nxt.phase = PH_IDLE;
              res.emit  = 1'b1;
              if (cur.recent) begin
                nxt.pop  = 1'b1;
                res.kind = KIND_SELF;
              end else begin
                res.kind = KIND_START;
              end
            end
          end
          PH_PI: begin
            if (b == CH_QUEST) nxt.phase = PH_PI_Q;
          end
          PH_PI_Q: begin
            if (b == CH_GT) begin
              if (cur.nest != 8'd0) begin
                nxt.phase = PH_DTD;
              end else begin
                nxt.phase = PH_IDLE;
                res.emit  = 1'b1;
                res.kind  = KIND_PI;
              end
            end else if (b != CH_QUEST) begin
              nxt.phase = PH_PI;
            end
          end
          PH_BANG: begin
            if (b == CH_DASH) nxt.phase = PH_BANG_DASH;
            else no_dash = 1'b1;
          end
          PH_BANG_DASH: begin
            if (b == CH_DASH) nxt.phase = PH_CMT;
            else no_dash = 1'b1;
          end
          PH_CDATA_PFX: begin
            if (cur.match < CDATA_LEN && b == cdata_char(cur.match)) begin
              nxt.match = cur.match + 3'd1;
              if (nxt.match == CDATA_LEN) nxt.phase = PH_CD;
            end else begin
              nxt.nest = 8'd1;
              do_dtd   = 1'b1;
            end
          end
          PH_CMT: begin
            if (b == CH_DASH) nxt.phase = PH_CMT_D1;
          end
          PH_CMT_D1: begin
            nxt.phase = (b == CH_DASH) ? PH_CMT_D2 : PH_CMT;
          end
          PH_CMT_D2: begin
            if (b == CH_GT) begin
              if (cur.nest != 8'd0) begin
                nxt.phase = PH_DTD;
              end else begin
                nxt.phase = PH_IDLE;
                res.emit  = 1'b1;
                res.kind  = KIND_CMT;
              end
            end else if (b != CH_DASH) begin
              nxt.phase = PH_CMT;
            end
          end
          PH_CD: begin
            if (b == CH_RBRK) nxt.phase = PH_CD_B1;
          end
          PH_CD_B1: begin
            nxt.phase = (b == CH_RBRK) ? PH_CD_B2 : PH_CD;
          end
          PH_CD_B2: begin
            if (b == CH_GT) begin
              nxt.phase = PH_IDLE;
              res.emit  = 1'b1;
              res.kind  = KIND_CDATA;
            end else if (b != CH_RBRK) begin
              nxt.phase = PH_CD;
            end
          end
          PH_DTD: begin
            do_dtd = 1'b1;
          end
          PH_DTD_LT: begin
            if (b == CH_BANG) nxt.phase = PH_DTD_BANG;
            else if (b == CH_QUEST) nxt.phase = PH_PI;
            else do_nest = 1'b1;
          end
          PH_DTD_BANG: begin
            if (b == CH_DASH) nxt.phase = PH_DTD_BANG_DASH;
            else do_nest = 1'b1;
          end
          PH_DTD_BANG_DASH: begin
            if (b == CH_DASH) nxt.phase = PH_CMT;
            else do_nest = 1'b1;
          end
          default: begin
            nxt.halted = 1'b1;
            nxt.phase  = PH_STOPPED;
            res.emit   = 1'b1;
            res.kind   = KIND_STOP;
            res.err    = ERR_NONE;
          end
        endcase

        // bang not followed by a comment dash: cdata inside elements, else dtd
        if (no_dash) begin
          if (b == CH_LBRK && nxt.depth != 8'd0) begin
            nxt.phase = PH_CDATA_PFX;
            nxt.match = 3'd1;
          end else begin
            nxt.nest = 8'd1;
            do_dtd   = 1'b1;
          end
        end

        // nested bracket inside a dtd
        if (do_nest) begin
          if (cur.nest >= NEST_LIMIT) begin
            nxt.halted = 1'b1;
            nxt.phase  = PH_STOPPED;
            res.emit   = 1'b1;
            res.kind   = KIND_STOP;
            res.err    = ERR_NONE;
          end else begin
            nxt.nest = cur.nest + 8'd1;
            do_dtd   = 1'b1;
          end
        end

        // plain dtd byte
        if (do_dtd) begin
          nxt.phase = PH_DTD;
          if (b == CH_LT) begin
            nxt.phase = PH_DTD_LT;
          end else if (b == CH_GT) begin
            if (nxt.nest != 8'd0) nxt.nest = nxt.nest - 8'd1;
            if (nxt.nest == 8'd0) begin
              nxt.phase = PH_IDLE;
              res.emit  = 1'b1;
              res.kind  = KIND_DTD;
            end
          end
        end
      end
    end

    res.depth = nxt.depth;
    res.len   = text_put ? cur.len : nxt.len;
  end

endmodule

>>> hw/rtl/xml_item_tokenizer_core.sv
// top level of the xml item tokenizer: state register, step logic, result register
`timescale 1ns / 1ps

//  channel | dir | tdata (low bit up)                      | tuser
//  --------+-----+-----------------------------------------+-----------------
//  s_      | in  | data_byte[7:0]                          | command[1:0]
//  m_      | out | depth[7:0], item_length[15:0],          | item_kind[3:0]
//          |     | error_code[1:0], 6 zero bits            |
//
//  one request per cycle unless the result register stalls; a result, when
//  the request makes one, is offered in the cycle after the request is taken
//  the single pass through the phase decoder and the depth/length counters
//  between the state register and the result register sets this rate
//  rst (synchronous, active high) leaves the scanner stopped until a begin
//  command arrives
//  a stalled result register holds s_tready low only while it is full and
//  m_tready is low; otherwise requests keep flowing

module xml_item_tokenizer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte[7:0]
  input  logic [1:0]  s_tuser,   // command[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // depth[7:0], item_length[23:8], error_code[25:24], zeros
  output logic [3:0]  m_tuser    // item_kind[3:0]
);
  import xit_pkg::*;

  xit_state_t  state;
  xit_state_t  state_next;
  xit_result_t res;

  logic        accept;

  // result register
  logic [3:0]  out_kind;
  logic [7:0]  out_depth;
  logic [15:0] out_len;
  logic [1:0]  out_err;

  // the result register frees up when it is empty or being drained
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  xit_step u_step (
    .cur (state),
    .cmd (s_tuser),
    .b   (s_tdata),
    .nxt (state_next),
    .res (res)
  );

  // scanner state advances once per request
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (accept) begin
      state <= state_next;
    end
  end

  // output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept && res.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // output payload, loaded only with a fresh result
  always_ff @(posedge clk) begin
    if (accept && res.emit) begin
      out_kind  <= res.kind;
      out_depth <= res.depth;
      out_len   <= res.len;
      out_err   <= res.err;
    end
  end

  assign m_tdata = {6'd0, out_err, out_len, out_depth};
  assign m_tuser = out_kind;

`ifndef NO_ASSERTIONS
  // a halted scanner always sits in the stopped phase
  a_halt_phase: assert property (@(posedge clk) disable iff (rst)
    state.halted |-> state.phase == PH_STOPPED)
    else $error("halted scanner outside stopped phase");

  // a pending element close always has an element to close
  a_pop_depth: assert property (@(posedge clk) disable iff (rst)
    state.pop |-> state.depth != 8'd0)
    else $error("pending close at depth zero");

  // only a stop result carries an error code
  a_err_stop: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_err != ERR_NONE |-> out_kind == KIND_STOP)
    else $error("error code on a non-stop result");

  // a halted scanner stays halted until a begin command
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    accept && state.halted && s_tuser != CMD_BEGIN |=> state.halted)
    else $error("scanner left halt without begin");
`endif

endmodule
